// ===== hdl/tiled_mosaic_to_bayer_raster_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tiled mosaic to Bayer raster core.
// Each macro checks a property on the rising edge of i_clk, with the
// checks switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TILED_MOSAIC_TO_BAYER_RASTER_CORE_MACROS_SVH
`define TILED_MOSAIC_TO_BAYER_RASTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMBR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tmbr_pkg.sv =====
// ----------------------------------------------------------------------------
// tmbr_pkg
// Sizes, codes, transfer types and helper functions shared by the
// tiled mosaic to Bayer raster core, its register file and its emit map.
// ----------------------------------------------------------------------------
package tmbr_pkg;

    // Frame geometry.
    localparam int MAX_WIDTH = 2048;
    localparam int TILE_SIZE = 16;
    localparam int HALF_TILE = TILE_SIZE / 2;
    localparam int MAX_TILES = MAX_WIDTH / TILE_SIZE;

    // Derived widths.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(TILE_SIZE);
    localparam int POS_W   = COL_W + 1;
    localparam int TILES_W = $clog2(MAX_TILES + 1);
    localparam int ADDR_W  = 1 + ROW_W + COL_W;
    localparam int DEPTH   = 2 ** ADDR_W;

    // Averaging: up to a 4x4 block, so a read index of four bits.
    localparam int MAX_SHIFT = 2;
    localparam int J_W       = 2 * MAX_SHIFT;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = PIX_W + J_W;

    // Register field widths.
    localparam int TA_W    = 8;
    localparam int TR_W    = 11;
    localparam int SC_W    = 2;
    localparam int STRIP_W = 10;

    // Configuration port.
    localparam int REG_IDX_W = 2;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_TILES_ACROSS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TILE_ROWS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_MODE   = 2'd2;

    // Scale modes.
    localparam logic [SC_W-1:0] SCALE_FULL = 2'd0;
    localparam logic [SC_W-1:0] SCALE_HALF = 2'd1;

    // Input commands.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [TA_W-1:0] tiles_across;
        logic [TR_W-1:0] tile_rows;
        logic [SC_W-1:0] scale_mode;
    } t_cfg;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_out_item;

    // Source position of the current output pixel and the position after it.
    typedef struct packed {
        logic [1:0]       shift;
        logic [COL_W-1:0] col0;
        logic [ROW_W-1:0] row0;
        logic [COL_W-1:0] col_next;
        logic [ROW_W-1:0] row_next;
        logic             strip_end;
    } t_emit_map;

    // Tile count with zero taken as one and large values saturated.
    function automatic logic [TILES_W-1:0] eff_tiles(input logic [TA_W-1:0] t);
        if (t == '0) begin
            return TILES_W'(1);
        end else if (int'(t) > MAX_TILES) begin
            return TILES_W'(MAX_TILES);
        end else begin
            return TILES_W'(t);
        end
    endfunction

    // Log2 of the averaging block edge; mode three acts as the 4x4 mode.
    function automatic logic [1:0] scale_shift(input logic [SC_W-1:0] m);
        case (m)
            SCALE_FULL: return 2'd0;
            SCALE_HALF: return 2'd1;
            default:    return 2'd2;
        endcase
    endfunction

endpackage

// ===== hdl/tmbr_ram.sv =====
// ----------------------------------------------------------------------------
// tmbr_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write when enabled; the read data is registered every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== hdl/tmbr_regs.sv =====
// ----------------------------------------------------------------------------
// tmbr_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module tmbr_regs
    import tmbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    t_cfg                 r_cfg;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tiles_across <= TA_W'(1);
            r_cfg.tile_rows    <= TR_W'(1);
            r_cfg.scale_mode   <= SCALE_FULL;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TILES_ACROSS: r_cfg.tiles_across <= pwdata[TA_W-1:0];
                REG_TILE_ROWS:    r_cfg.tile_rows    <= pwdata[TR_W-1:0];
                REG_SCALE_MODE:   r_cfg.scale_mode   <= pwdata[SC_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data.
    always_comb begin
        case (reg_idx)
            REG_TILES_ACROSS: prdata = PDATA_W'(r_cfg.tiles_across);
            REG_TILE_ROWS:    prdata = PDATA_W'(r_cfg.tile_rows);
            REG_SCALE_MODE:   prdata = PDATA_W'(r_cfg.scale_mode);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/tmbr_emit_map.sv =====
// ----------------------------------------------------------------------------
// tmbr_emit_map
// Maps the output raster position to the top-left source pixel of its
// averaging block and works out the following output position.
// ----------------------------------------------------------------------------
module tmbr_emit_map
    import tmbr_pkg::*;
(
    input  t_cfg             i_cfg,
    input  logic [COL_W-1:0] i_emit_column,
    input  logic [ROW_W-1:0] i_emit_row,
    output t_emit_map        o_map
);

    logic [1:0]       sh;
    logic [ROW_W:0]   per;
    logic [POS_W-1:0] out_w;
    logic [POS_W-1:0] col_sat;
    logic [POS_W-1:0] col_inc;
    logic [ROW_W:0]   row_sat;
    logic [ROW_W:0]   row_inc;
    logic [ROW_W-1:0] idx;
    logic [COL_W-1:0] tile_base;
    logic             col_wrap;
    logic             row_wrap;

    always_comb begin
        // Output pixels per tile edge and per strip row.
        sh    = scale_shift(i_cfg.scale_mode);
        per   = (ROW_W + 1)'(TILE_SIZE) >> sh;
        out_w = POS_W'(eff_tiles(i_cfg.tiles_across)) << (ROW_W - int'(sh));

        // Positions beyond the current output size stick to the last one.
        col_sat = ({1'b0, i_emit_column} >= out_w) ? out_w - POS_W'(1)
                                                   : {1'b0, i_emit_column};
        row_sat = ({1'b0, i_emit_row} >= per) ? per - (ROW_W + 1)'(1)
                                              : {1'b0, i_emit_row};

        // Even outputs come from the left half of the tile, odd from the right.
        idx       = ROW_W'(col_sat) & ROW_W'(per - (ROW_W + 1)'(1));
        tile_base = COL_W'((col_sat >> (ROW_W - int'(sh))) << ROW_W);
        o_map.col0 = tile_base + COL_W'(ROW_W'(idx >> 1) << sh)
                   + (idx[0] ? COL_W'(HALF_TILE) : '0);
        o_map.row0 = ROW_W'(ROW_W'(row_sat >> 1) << sh)
                   + (row_sat[0] ? ROW_W'(HALF_TILE) : '0);

        // Advance along the row, then to the next row, then to the next strip.
        col_inc  = col_sat + POS_W'(1);
        row_inc  = row_sat + (ROW_W + 1)'(1);
        col_wrap = col_inc >= out_w;
        row_wrap = row_inc >= per;

        o_map.shift     = sh;
        o_map.col_next  = col_wrap ? '0 : COL_W'(col_inc);
        o_map.row_next  = col_wrap ? (row_wrap ? '0 : ROW_W'(row_inc)) : ROW_W'(row_sat);
        o_map.strip_end = col_wrap & row_wrap;
    end

endmodule

// ===== hdl/tiled_mosaic_to_bayer_raster_core.sv =====
// Throughput: items that produce no output pixel can follow each other in every
// cycle. For an item that produces a pixel, the s*s source pixels are read one
// per cycle from the single-port strip memory, then the last read is drained
// and the pixel waits in the emit state while the previous pixel is still held
// in the output register; no new item is accepted until the pixel is emitted.
// Reset clears positions, bank flags and output valid; the strip memory is not cleared.
// ----------------------------------------------------------------------------
// tiled_mosaic_to_bayer_raster_core
// Stores 16-row strips of a tiled frame in two memory banks and reads the
// previous strip back as a Bayer raster, optionally averaged.
// ----------------------------------------------------------------------------
`include "tiled_mosaic_to_bayer_raster_core_macros.svh"

module tiled_mosaic_to_bayer_raster_core
    import tmbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    t_cfg       cfg;
    t_emit_map  map;

    logic [1:0]         r_state, n_state;
    logic [J_W-1:0]     r_j, n_j;
    logic               r_rd_pend;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [COL_W-1:0]   r_col0;
    logic [ROW_W-1:0]   r_row0;
    logic               r_cmd;
    logic [PIX_W-1:0]   r_pixel;
    logic [COL_W-1:0]   r_emit_column, n_emit_column;
    logic [ROW_W-1:0]   r_emit_row, n_emit_row;
    logic               r_emit_bank, n_emit_bank;
    logic [STRIP_W-1:0] r_strip, n_strip;
    logic [COL_W-1:0]   r_fill_column, n_fill_column;
    logic [ROW_W-1:0]   r_fill_row, n_fill_row;
    logic               r_fill_bank, n_fill_bank;
    logic [1:0]         r_bank_ready, n_bank_ready;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               in_acc;
    logic               emit_rdy;
    logic               out_free;
    logic               do_emit;
    logic               do_store;
    logic               read_busy;
    logic [J_W-1:0]     j_last;
    logic [J_W-1:0]     blk_k;
    logic [J_W-1:0]     blk_l;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  fill_addr;
    logic [ADDR_W-1:0]  ram_addr;
    logic [PIX_W-1:0]   ram_wdata;
    logic [PIX_W-1:0]   ram_rdata;
    logic               ram_we;
    logic [POS_W-1:0]   fill_w;
    logic [POS_W-1:0]   fill_col_inc;
    logic               fill_col_wrap;
    logic               fill_strip_done;
    logic [TR_W-1:0]    strip_inc;
    logic               frame_end;

    // Configuration registers.
    tmbr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Output position to source position mapping.
    tmbr_emit_map u_map (
        .i_cfg         (cfg),
        .i_emit_column (r_emit_column),
        .i_emit_row    (r_emit_row),
        .o_map         (map)
    );

    // Strip memory: both banks in one single-port RAM.
    tmbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_strip_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Handshake and access decisions.
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign emit_rdy    = r_bank_ready[r_emit_bank];
    assign out_free    = !r_out_valid || i_out_ready;
    assign do_emit     = (r_state == ST_EMIT) && out_free;
    assign do_store    = (in_acc && !emit_rdy && (i_in_data.cmd == CMD_PUSH))
                       || (do_emit && (r_cmd == CMD_PUSH));
    assign read_busy   = (r_state == ST_READ) || (r_state == ST_DRAIN);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Block read addressing: index j walks the s x s block row by row.
    assign j_last  = J_W'((1 << (2 * int'(map.shift))) - 1);
    assign blk_k   = r_j & J_W'((1 << int'(map.shift)) - 1);
    assign blk_l   = r_j >> map.shift;
    assign rd_addr = {r_emit_bank, r_row0 + ROW_W'(blk_l), r_col0 + COL_W'(blk_k)};

    // Fill addressing and wrap detection.
    assign fill_addr       = {r_fill_bank, r_fill_row, r_fill_column};
    assign fill_w          = POS_W'(eff_tiles(cfg.tiles_across)) << ROW_W;
    assign fill_col_inc    = {1'b0, r_fill_column} + POS_W'(1);
    assign fill_col_wrap   = fill_col_inc >= fill_w;
    assign fill_strip_done = fill_col_wrap && (r_fill_row == ROW_W'(TILE_SIZE - 1));

    // The memory is written only when no block read is in flight.
    assign ram_we    = do_store;
    assign ram_addr  = do_store ? fill_addr : rd_addr;
    assign ram_wdata = (r_state == ST_IDLE) ? i_in_data.pixel_in : r_pixel;

    // Frame end detection on the strip counter.
    assign strip_inc = TR_W'(r_strip) + TR_W'(1);
    assign frame_end = strip_inc >= cfg.tile_rows;

    // Next-state logic of the sequencer and the stored positions.
    always_comb begin
        n_state       = r_state;
        n_j           = r_j;
        n_sum         = r_rd_pend ? r_sum + SUM_W'(ram_rdata) : r_sum;
        n_emit_column = r_emit_column;
        n_emit_row    = r_emit_row;
        n_emit_bank   = r_emit_bank;
        n_strip       = r_strip;
        n_fill_column = r_fill_column;
        n_fill_row    = r_fill_row;
        n_fill_bank   = r_fill_bank;
        n_bank_ready  = r_bank_ready;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;

        case (r_state)
            ST_IDLE: begin
                if (in_acc && emit_rdy) begin
                    n_state = ST_READ;
                    n_j     = '0;
                    n_sum   = '0;
                end
            end
            ST_READ: begin
                n_j = r_j + J_W'(1);
                if (r_j == j_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Output pixel and advance of the drain position.
        if (do_emit) begin
            n_out_valid      = 1'b1;
            n_out.pixel_out  = PIX_W'(r_sum >> (2 * int'(map.shift)));
            n_out.frame_last = map.strip_end && frame_end;
            n_emit_column    = map.col_next;
            n_emit_row       = map.row_next;
            if (map.strip_end) begin
                n_bank_ready[r_emit_bank] = 1'b0;
                n_emit_bank               = ~r_emit_bank;
                n_strip                   = frame_end ? '0 : STRIP_W'(strip_inc);
            end
        end

        // Pixel store; a completed strip marks its bank after any drain clear.
        if (do_store) begin
            if (fill_col_wrap) begin
                n_fill_column = '0;
                if (fill_strip_done) begin
                    n_fill_row                = '0;
                    n_bank_ready[r_fill_bank] = 1'b1;
                    n_fill_bank               = ~r_fill_bank;
                end else begin
                    n_fill_row = r_fill_row + ROW_W'(1);
                end
            end else begin
                n_fill_column = COL_W'(fill_col_inc);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_j           <= '0;
            r_rd_pend     <= 1'b0;
            r_emit_column <= '0;
            r_emit_row    <= '0;
            r_emit_bank   <= 1'b0;
            r_strip       <= '0;
            r_fill_column <= '0;
            r_fill_row    <= '0;
            r_fill_bank   <= 1'b0;
            r_bank_ready  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_j           <= n_j;
            r_rd_pend     <= (r_state == ST_READ);
            r_emit_column <= n_emit_column;
            r_emit_row    <= n_emit_row;
            r_emit_bank   <= n_emit_bank;
            r_strip       <= n_strip;
            r_fill_column <= n_fill_column;
            r_fill_row    <= n_fill_row;
            r_fill_bank   <= n_fill_bank;
            r_bank_ready  <= n_bank_ready;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers: accumulator, block origin, held item, output pixel.
    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_out <= n_out;
        if (in_acc) begin
            r_cmd   <= i_in_data.cmd;
            r_pixel <= i_in_data.pixel_in;
            r_col0  <= map.col0;
            r_row0  <= map.row0;
        end
    end

    // Checks on the sequencer and the memory port.
    `TMBR_ASSERT_SAME(a_no_write_during_read, ram_we, !read_busy, "write during a block read")
    `TMBR_ASSERT_SAME(a_read_ready_bank, r_state == ST_READ, emit_rdy, "read of an empty bank")
    `TMBR_ASSERT_SAME(a_block_index_bound, r_state == ST_READ, r_j <= j_last, "block index too big")
    `TMBR_ASSERT_NEXT(a_emit_loads_output, do_emit, o_out_valid, "emitted pixel not presented")

endmodule
